>>> src/sffc_pkg.sv
package sffc_pkg;

    localparam int FRAME_BYTES    = 26;
    localparam int MAX_UNICAST_ID = 14;
    localparam int CNT_W          = 5;
    localparam int ID_W           = 4;

    localparam logic [31:0]      CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]       HDR_BYTE0 = 8'hFC;
    localparam logic [7:0]       HDR_BYTE1 = 8'hEE;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ID      = 3'd1,
        ST_LENGTH      = 3'd2,
        ST_HEADER      = 3'd3,
        ST_CRC         = 3'd4,
        ST_ID_MISMATCH = 3'd5
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        [2:0]  status_code;
        logic        [7:0]  mode_byte;
        logic signed [7:0]  temperature;
        logic        [7:0]  winding_temperature;
        logic        [7:0]  voltage_half_volts;
        logic signed [15:0] torque_raw;
        logic signed [15:0] speed_raw;
        logic signed [31:0] position_raw;
        logic        [31:0] error_word;
        logic        [12:0] external_position;
        logic        [2:0]  extra_flags;
        logic        [15:0] aux_word;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result data;
    } t_push;

    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int b = 0; b < 32; b++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/sffc_byte_if.sv
interface sffc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

>>> src/sffc_result_if.sv
interface sffc_result_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status_code;
    logic        [7:0]  mode_byte;
    logic signed [7:0]  temperature;
    logic        [7:0]  winding_temperature;
    logic        [7:0]  voltage_half_volts;
    logic signed [15:0] torque_raw;
    logic signed [15:0] speed_raw;
    logic signed [31:0] position_raw;
    logic        [31:0] error_word;
    logic        [12:0] external_position;
    logic        [2:0]  extra_flags;
    logic        [15:0] aux_word;

    modport source (
        output valid, output status_code, output mode_byte, output temperature,
        output winding_temperature, output voltage_half_volts, output torque_raw,
        output speed_raw, output position_raw, output error_word,
        output external_position, output extra_flags, output aux_word,
        input ready
    );
    modport sink (
        input valid, input status_code, input mode_byte, input temperature,
        input winding_temperature, input voltage_half_volts, input torque_raw,
        input speed_raw, input position_raw, input error_word,
        input external_position, input extra_flags, input aux_word,
        output ready
    );
endinterface

>>> src/sffc_in_stage.sv
module sffc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sffc_byte_if.sink           i_in,
    input  logic                i_take,
    output sffc_pkg::t_item     o_item
);
    import sffc_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_in.rx_byte;
            r_last <= i_in.last_byte;
        end
    end

    assign o_item = '{valid: r_valid, rx_byte: r_byte, last_byte: r_last};
endmodule

>>> src/sffc_parser.sv
module sffc_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sffc_pkg::ID_W-1:0]   i_cfg_wdata,
    input  sffc_pkg::t_item             i_item,
    input  logic                        i_space,
    output logic                        o_take,
    output sffc_pkg::t_push             o_push
);
    import sffc_pkg::*;

    logic [ID_W-1:0]  r_exp_id;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [31:0]      r_crc;
    logic [31:0]      n_crc;
    logic [7:0]       r_buf [FRAME_BYTES];
    logic [7:0]       n_buf [FRAME_BYTES];
    logic [CNT_W-1:0] w_count;
    logic [31:0]      w_word;
    logic             w_crc_hit;
    logic [15:0]      w_ext;
    t_result          w_res;

    assign o_take = i_item.valid && (!i_item.last_byte || i_space);

    always_comb begin
        n_buf = r_buf;
        if (r_cnt < CNT_W'(FRAME_BYTES)) begin
            n_buf[r_cnt] = i_item.rx_byte;
        end
        w_crc_hit = 1'b1;
        case (r_cnt)
            5'd5:    w_word = {n_buf[5],  n_buf[4],  n_buf[3],  n_buf[2]};
            5'd9:    w_word = {n_buf[9],  n_buf[8],  n_buf[7],  n_buf[6]};
            5'd13:   w_word = {n_buf[13], n_buf[12], n_buf[11], n_buf[10]};
            5'd17:   w_word = {n_buf[17], n_buf[16], n_buf[15], n_buf[14]};
            5'd21:   w_word = {n_buf[21], n_buf[20], n_buf[19], n_buf[18]};
            default: begin
                w_word    = '0;
                w_crc_hit = 1'b0;
            end
        endcase
        w_count = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : CNT_MAX;
        if (i_item.last_byte) begin
            n_cnt = '0;
            n_crc = CRC_INIT;
        end else begin
            n_cnt = w_count;
            n_crc = w_crc_hit ? crc32_word(r_crc, w_word) : r_crc;
        end
    end

    always_comb begin
        w_res = '0;
        w_ext = {n_buf[19], n_buf[18]};
        if (r_exp_id > ID_W'(MAX_UNICAST_ID)) begin
            w_res.status_code = ST_BAD_ID;
        end else if (w_count != CNT_W'(FRAME_BYTES)) begin
            w_res.status_code = ST_LENGTH;
        end else begin
            w_res.mode_byte = n_buf[2];
            if (n_buf[0] != HDR_BYTE0 || n_buf[1] != HDR_BYTE1) begin
                w_res.status_code = ST_HEADER;
            end else if ({n_buf[25], n_buf[24], n_buf[23], n_buf[22]} != r_crc) begin
                w_res.status_code = ST_CRC;
            end else if (n_buf[2][3:0] != r_exp_id) begin
                w_res.status_code = ST_ID_MISMATCH;
            end else begin
                w_res.status_code         = ST_OK;
                w_res.temperature         = n_buf[3];
                w_res.winding_temperature = n_buf[4];
                w_res.voltage_half_volts  = n_buf[5];
                w_res.torque_raw          = {n_buf[7], n_buf[6]};
                w_res.speed_raw           = {n_buf[9], n_buf[8]};
                w_res.position_raw        = {n_buf[13], n_buf[12], n_buf[11], n_buf[10]};
                w_res.error_word          = {n_buf[17], n_buf[16], n_buf[15], n_buf[14]};
                w_res.external_position   = w_ext[12:0];
                w_res.extra_flags         = w_ext[15:13];
                w_res.aux_word            = {n_buf[21], n_buf[20]};
            end
        end
    end

    assign o_push = '{push: o_take && i_item.last_byte, data: w_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_id <= '0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_exp_id <= i_cfg_wdata;
            end
            if (o_take) begin
                r_cnt <= n_cnt;
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_buf <= n_buf;
        end
    end
endmodule

>>> src/sffc_out_queue.sv
module sffc_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sffc_pkg::t_push     i_push,
    output logic                o_space,
    sffc_result_if.source       o_out
);
    import sffc_pkg::*;

    t_result    r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_pop;
    t_result    w_head;

    assign w_pop   = o_out.valid && o_out.ready;
    assign o_space = (r_cnt != 2'd2) || w_pop;
    assign w_head  = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push.push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_data[r_wptr] <= i_push.data;
        end
    end

    assign o_out.valid               = (r_cnt != 2'd0);
    assign o_out.status_code         = w_head.status_code;
    assign o_out.mode_byte           = w_head.mode_byte;
    assign o_out.temperature         = w_head.temperature;
    assign o_out.winding_temperature = w_head.winding_temperature;
    assign o_out.voltage_half_volts  = w_head.voltage_half_volts;
    assign o_out.torque_raw          = w_head.torque_raw;
    assign o_out.speed_raw           = w_head.speed_raw;
    assign o_out.position_raw        = w_head.position_raw;
    assign o_out.error_word          = w_head.error_word;
    assign o_out.external_position   = w_head.external_position;
    assign o_out.extra_flags         = w_head.extra_flags;
    assign o_out.aux_word            = w_head.aux_word;
endmodule

>>> src/servo_feedback_frame_checker_top.sv
// Channel   Direction  Handshake     Payload
// i_in      in         valid/ready   rx_byte, last_byte
// o_out     out        valid/ready   status_code and the eleven frame fields
// i_cfg_*   in         write enable  expected motor ID, 4 bits
//
// One byte per cycle unless a last byte waits for queue space; a frame's result
// is pushed as its last byte leaves the input register for word CRC and checks.
// Synchronous active-low reset clears the byte count, CRC, config and queues.
// The two-entry result queue keeps bytes flowing while a result waits; a last
// byte stalls only when both entries are full.
module servo_feedback_frame_checker_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sffc_pkg::ID_W-1:0]   i_cfg_wdata,
    sffc_byte_if.sink                   i_in,
    sffc_result_if.source               o_out
);
    import sffc_pkg::*;

    t_item w_item;
    t_push w_push;
    logic  w_take;
    logic  w_space;

    sffc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    sffc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_item),
        .i_space     (w_space),
        .o_take      (w_take),
        .o_push      (w_push)
    );

    sffc_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_out   (o_out)
    );
endmodule

>>> tb/sv/testbench.sv
module testbench;
    import sffc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_FRAME = 40;

    typedef enum {FR_GOOD, FR_HEADER, FR_CRC, FR_ID, FR_SHORT, FR_LONG, FR_NOISE} frame_kind_e;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_xfer_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [ID_W-1:0] cfg_wdata;

    sffc_byte_if   in_if();
    sffc_result_if out_if();

    servo_feedback_frame_checker_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    byte_xfer_t pending[$];
    t_result    reports_due[$];

    logic [ID_W-1:0] motor_id = '0;
    int              rx_count = 0;
    logic [31:0]     rx_crc = CRC_INIT;
    logic [7:0]      rx_frame [0:FRAME_BYTES-1];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int reports_seen = 0;
    int error_count = 0;
    int status_hits [0:7];
    int idle_mode = 0;
    int send_idle_pct [0:2] = '{25, 71, 0};
    int recv_idle_pct [0:2] = '{71, 25, 0};
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic byte_taken = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [31:0] word);
        logic [31:0] c;
        c = acc ^ word;
        repeat (32) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] rx_le16(input int at);
        return {rx_frame[at+1], rx_frame[at]};
    endfunction

    function automatic logic [31:0] rx_le32(input int at);
        return {rx_le16(at + 2), rx_le16(at)};
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            flag_error($sformatf("report %0d %s: expected %0h actual %0h",
                                 reports_seen, name, want, got));
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int          idx;
        int          cnt;
        t_result     r;
        logic [15:0] ext;
        idx = rx_count;
        if (idx < FRAME_BYTES) begin
            rx_frame[idx] = b;
            if (idx >= 5 && idx <= 21 && ((idx - 2) % 4) == 3) begin
                rx_crc = crc_fold(rx_crc, rx_le32(idx - 3));
            end
        end
        cnt = (idx < int'(CNT_MAX)) ? idx + 1 : int'(CNT_MAX);
        if (!last) begin
            rx_count = cnt;
            return;
        end
        r = '0;
        if (motor_id > MAX_UNICAST_ID) begin
            r.status_code = ST_BAD_ID;
        end else if (cnt != FRAME_BYTES) begin
            r.status_code = ST_LENGTH;
        end else begin
            r.mode_byte = rx_frame[2];
            if (rx_frame[0] != HDR_BYTE0 || rx_frame[1] != HDR_BYTE1) begin
                r.status_code = ST_HEADER;
            end else if (rx_le32(22) != rx_crc) begin
                r.status_code = ST_CRC;
            end else if (rx_frame[2][3:0] != motor_id) begin
                r.status_code = ST_ID_MISMATCH;
            end else begin
                ext = rx_le16(18);
                r.status_code         = ST_OK;
                r.temperature         = rx_frame[3];
                r.winding_temperature = rx_frame[4];
                r.voltage_half_volts  = rx_frame[5];
                r.torque_raw          = rx_le16(6);
                r.speed_raw           = rx_le16(8);
                r.position_raw        = rx_le32(10);
                r.error_word          = rx_le32(14);
                r.external_position   = ext[12:0];
                r.extra_flags         = ext[15:13];
                r.aux_word            = rx_le16(20);
            end
        end
        status_hits[r.status_code]++;
        reports_due.push_back(r);
        rx_count = 0;
        rx_crc = CRC_INIT;
    endtask

    task automatic check_report();
        t_result want;
        if (reports_due.size() == 0) begin
            flag_error($sformatf("unexpected report, status %0d", out_if.status_code));
            return;
        end
        want = reports_due.pop_front();
        field_check("status_code", want.status_code, out_if.status_code);
        field_check("mode_byte", want.mode_byte, out_if.mode_byte);
        field_check("temperature", want.temperature, out_if.temperature);
        field_check("winding_temperature", want.winding_temperature,
                    out_if.winding_temperature);
        field_check("voltage_half_volts", want.voltage_half_volts, out_if.voltage_half_volts);
        field_check("torque_raw", want.torque_raw, out_if.torque_raw);
        field_check("speed_raw", want.speed_raw, out_if.speed_raw);
        field_check("position_raw", want.position_raw, out_if.position_raw);
        field_check("error_word", want.error_word, out_if.error_word);
        field_check("external_position", want.external_position, out_if.external_position);
        field_check("extra_flags", want.extra_flags, out_if.extra_flags);
        field_check("aux_word", want.aux_word, out_if.aux_word);
        reports_seen++;
    endtask

    task automatic queue_frame(input frame_kind_e kind, input fill_e fill, input int len);
        logic [7:0]  f [0:MAX_FRAME-1];
        logic [31:0] acc;
        int          n;
        int          pos;
        for (int i = 0; i < MAX_FRAME; i++) begin
            f[i] = (fill == FILL_ZERO) ? 8'h00 :
                   (fill == FILL_ONES) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        f[0] = HDR_BYTE0;
        f[1] = HDR_BYTE1;
        f[2][3:0] = (kind == FR_ID) ? motor_id ^ 4'($urandom_range(1, 15)) : motor_id;
        acc = CRC_INIT;
        for (int w = 0; w < 5; w++) begin
            acc = crc_fold(acc, {f[5+4*w], f[4+4*w], f[3+4*w], f[2+4*w]});
        end
        {f[25], f[24], f[23], f[22]} = acc;
        case (kind)
            FR_HEADER: begin
                pos = $urandom_range(0, 1);
                f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
            end
            FR_CRC: begin
                pos = $urandom_range(2, 25);
                f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            FR_NOISE: begin
                for (int i = 0; i < MAX_FRAME; i++) begin
                    f[i] = 8'($urandom_range(0, 255));
                end
            end
            default: ;
        endcase
        if (len > 0) begin
            n = len;
        end else begin
            case (kind)
                FR_SHORT: n = $urandom_range(1, FRAME_BYTES - 1);
                FR_LONG:  n = $urandom_range(FRAME_BYTES + 1, MAX_FRAME);
                FR_NOISE: n = $urandom_range(1, MAX_FRAME);
                default:  n = FRAME_BYTES;
            endcase
        end
        for (int i = 0; i < n; i++) begin
            pending.push_back('{data: f[i], last: (i == n - 1)});
        end
        bytes_queued += n;
    endtask

    task automatic program_id(input logic [ID_W-1:0] id);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= id;
        motor_id = id;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (bytes_accepted != bytes_queued || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(negedge clk) begin
        byte_xfer_t nxt;
        if (!in_if.valid || byte_taken) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct[idle_mode]) begin
                nxt = pending.pop_front();
                in_if.valid <= 1'b1;
                in_if.rx_byte <= nxt.data;
                in_if.last_byte <= nxt.last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver, with long hold-offs on request
    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = $urandom_range(150, 250);
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct[idle_mode]);
        end
    end

    always @(posedge clk) begin
        byte_taken <= in_if.valid && in_if.ready;
        if (rst_n && in_if.valid && in_if.ready) begin
            absorb_byte(in_if.rx_byte, in_if.last_byte);
            bytes_accepted++;
        end
        if (rst_n && out_if.valid && out_if.ready) begin
            check_report();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          budget;
        int          start;
        int          r;
        frame_kind_e kind;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.rx_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        for (int i = 0; i < 8; i++) begin
            status_hits[i] = 0;
        end
        for (int i = 0; i < FRAME_BYTES; i++) begin
            rx_frame[i] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        program_id(4'd0);
        queue_frame(FR_GOOD, FILL_ZERO, 0);
        queue_frame(FR_GOOD, FILL_ONES, 0);
        queue_frame(FR_SHORT, FILL_RANDOM, 1);
        queue_frame(FR_SHORT, FILL_RANDOM, FRAME_BYTES - 1);
        queue_frame(FR_LONG, FILL_RANDOM, FRAME_BYTES + 1);
        queue_frame(FR_LONG, FILL_ONES, MAX_FRAME);
        queue_frame(FR_HEADER, FILL_RANDOM, 0);
        queue_frame(FR_CRC, FILL_RANDOM, 0);
        queue_frame(FR_ID, FILL_RANDOM, 0);
        wait_idle();
        program_id(4'd15);
        queue_frame(FR_GOOD, FILL_RANDOM, 0);
        queue_frame(FR_SHORT, FILL_RANDOM, 0);
        wait_idle();
        program_id(4'd14);
        queue_frame(FR_GOOD, FILL_ONES, 0);
        queue_frame(FR_ID, FILL_ZERO, 0);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            program_id(p == 1 ? 4'd14 : p == 4 ? 4'd15 : 4'($urandom_range(0, MAX_UNICAST_ID)));
            idle_mode = p / 2;
            if (p == 0 || p == 5) begin
                hold_requests++;
            end
            budget = (p == 4) ? 120 : 330;
            start = bytes_queued;
            while (bytes_queued - start < budget) begin
                r = $urandom_range(0, 99);
                kind = (r < 65) ? FR_GOOD : (r < 70) ? FR_HEADER : (r < 75) ? FR_CRC :
                       (r < 80) ? FR_ID : (r < 87) ? FR_SHORT : (r < 93) ? FR_LONG : FR_NOISE;
                queue_frame(kind, FILL_RANDOM, 0);
            end
            wait_idle();
        end

        if (reports_due.size() != 0) begin
            flag_error($sformatf("%0d reports never arrived", reports_due.size()));
        end
        $display("Run covered %0d bytes and %0d frame reports, %0d errors.",
                 bytes_accepted, reports_seen, error_count);
        $display("Statuses: ok %0d, bad id %0d, length %0d, header %0d, crc %0d, id %0d.",
                 status_hits[ST_OK], status_hits[ST_BAD_ID], status_hits[ST_LENGTH],
                 status_hits[ST_HEADER], status_hits[ST_CRC], status_hits[ST_ID_MISMATCH]);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
src/sffc_pkg.sv
src/sffc_byte_if.sv
src/sffc_result_if.sv
src/sffc_in_stage.sv
src/sffc_parser.sv
src/sffc_out_queue.sv
src/servo_feedback_frame_checker_top.sv
tb/sv/testbench.sv
